>>> sv/hpt_pkg.sv
// hpt_pkg: shared widths, register codes and payload types of the point transform core
`default_nettype none

package hpt_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ENTRY_BITS    = 32;
  localparam int CFG_REGS      = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int PROD_W        = ENTRY_BITS + COORD_WIDTH;
  localparam int ACC_W         = PROD_W + 2;
  localparam int QUO_W         = COORD_WIDTH;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_A,
    REG_ROW0_B,
    REG_ROW1_A,
    REG_ROW1_B,
    REG_ROW2_A,
    REG_ROW2_B,
    REG_ROW3_A,
    REG_ROW3_B
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] DIAG_LO = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] DIAG_HI = 64'h0001_0000_0000_0000;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;
    logic                          is_position;
  } in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          w_was_zero;
    logic                          saturated;
  } out_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [QUO_W:0]   q;
  } div_res_t;

  function automatic logic [CFG_DATA_W-1:0] reg_reset(cfg_reg_t idx);
    logic [CFG_DATA_W-1:0] v;
    case (idx)
      REG_ROW0_A: v = DIAG_LO;
      REG_ROW1_A: v = DIAG_HI;
      REG_ROW2_B: v = DIAG_LO;
      REG_ROW3_B: v = DIAG_HI;
      default:    v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> sv/hpt_matmul.sv
// hpt_matmul: registered products and row sums of the 4x4 matrix times the extended point
`default_nettype none

module hpt_matmul import hpt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  in_t                                  pt,
  input  logic [CFG_REGS-1:0][CFG_DATA_W-1:0]  mat,
  output logic signed [ACC_W-1:0]              acc [4]
);

  logic signed [COORD_WIDTH-1:0] coord [3];
  logic signed [PROD_W-1:0]      prod_r [4][4];
  logic signed [ACC_W-1:0]       acc_r [4];

  assign coord[0] = pt.in_x;
  assign coord[1] = pt.in_y;
  assign coord[2] = pt.in_z;

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      logic signed [ENTRY_BITS-1:0] entry;
      assign entry = $signed(mat[r*2 + c/2][(c%2)*ENTRY_BITS +: ENTRY_BITS]);
      if (c < 3) begin : g_mul
        logic signed [PROD_W-1:0] prod_nxt;
        assign prod_nxt = entry * coord[c];
        always_ff @(posedge clk) begin
          if (en) prod_r[r][c] <= prod_nxt;
        end
      end else begin : g_w
        always_ff @(posedge clk) begin
          if (en) prod_r[r][c] <= pt.is_position ? (PROD_W'(entry) <<< FRAC_BITS) : '0;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) acc_r[r] <= ACC_W'(prod_r[r][0]) + ACC_W'(prod_r[r][1])
                        + ACC_W'(prod_r[r][2]) + ACC_W'(prod_r[r][3]);
    end
    assign acc[r] = acc_r[r];
  end

endmodule

`default_nettype wire

>>> sv/hpt_div.sv
// hpt_div: pipelined restoring divider, one quotient bit per stage, rounded half up
`default_nettype none

module hpt_div import hpt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [ACC_W+FRAC_BITS-1:0]        num,
  input  logic [ACC_W-1:0]                  den,
  input  logic                              neg,
  output div_res_t                          res
);

  localparam int NW = ACC_W + FRAC_BITS;

  logic [ACC_W-1:0] rem_r [QUO_W+1];
  logic [ACC_W-1:0] den_r [QUO_W+1];
  logic [QUO_W-1:0] quo_r [QUO_W+1];
  logic [QUO_W-1:0] lo_r  [QUO_W+1];
  logic             neg_r [QUO_W+1];
  logic             ovf_r [QUO_W+1];

  logic [NW-1:0] hi_part;
  assign hi_part = num >> QUO_W;

  // quotient too wide for the result when the top part already reaches the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_part[ACC_W-1:0];
      den_r[0] <= den;
      quo_r[0] <= '0;
      lo_r[0]  <= num[QUO_W-1:0];
      neg_r[0] <= neg;
      ovf_r[0] <= hi_part >= NW'(den);
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [ACC_W:0] trial;
    logic [ACC_W:0] diff;
    logic           ge;
    assign trial = {rem_r[k-1], lo_r[k-1][QUO_W-1]};
    assign ge    = trial >= {1'b0, den_r[k-1]};
    assign diff  = trial - {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
        den_r[k] <= den_r[k-1];
        quo_r[k] <= {quo_r[k-1][QUO_W-2:0], ge};
        lo_r[k]  <= {lo_r[k-1][QUO_W-2:0], 1'b0};
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  logic rnd;
  assign rnd = {rem_r[QUO_W], 1'b0} >= {1'b0, den_r[QUO_W]};

  always_comb begin
    res.neg = neg_r[QUO_W];
    res.ovf = ovf_r[QUO_W];
    res.q   = {1'b0, quo_r[QUO_W]} + (QUO_W+1)'(rnd);
  end

endmodule

`default_nettype wire

>>> sv/homogeneous_point_transform_core.sv
// homogeneous_point_transform_core: 4x4 homogeneous transform with perspective divide
// Takes one point per clock and gives one result per clock while in_stall is low; the
// divide pipeline resolves one quotient bit per stage for each of x, y and z. in_stall
// is high exactly while a result waits on out_stall, and then the whole pipeline holds.
// Matrix registers are written through cfg_we/cfg_idx/cfg_wdata; the user must write them
// only while the pipeline is empty, as the block itself does not enforce it.
`default_nettype none

module homogeneous_point_transform_core import hpt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_t                   out_data,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int NW   = ACC_W + FRAC_BITS;
  localparam int LAST = QUO_W + 3;

  logic [CFG_REGS-1:0][CFG_DATA_W-1:0] mat_r;
  logic                                en;
  logic [LAST:0]                       vld_r;
  logic [QUO_W+1:0]                    wz_r;
  logic signed [ACC_W-1:0]             acc [4];
  logic [NW-1:0]                       num_r [3];
  logic [ACC_W-1:0]                    den_r [3];
  logic                                neg_r [3];
  logic [NW-1:0]                       num_nxt [3];
  logic [ACC_W-1:0]                    den_nxt [3];
  logic                                neg_nxt [3];
  logic                                wz_nxt;
  div_res_t                            res [3];
  logic                                out_valid_r;
  out_t                                out_r;
  out_t                                out_nxt;

  assign in_stall  = out_valid_r && out_stall;
  assign en        = !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_REGS; i++) mat_r[i] <= reg_reset(cfg_reg_t'(i));
    end else if (cfg_we) begin
      mat_r[cfg_idx] <= cfg_wdata;
    end
  end

  hpt_matmul #(.FRAC_BITS(FRAC_BITS)) u_matmul (
    .clk (clk),
    .en  (en),
    .pt  (in_data),
    .mat (mat_r),
    .acc (acc)
  );

  // sign and magnitude, divisor choice for zero w
  always_comb begin
    logic             wneg;
    logic [ACC_W-1:0] wmag;
    logic             xneg;
    logic [ACC_W-1:0] xmag;
    wneg   = acc[3][ACC_W-1];
    wmag   = wneg ? ACC_W'(-acc[3]) : ACC_W'(acc[3]);
    wz_nxt = acc[3] == '0;
    for (int c = 0; c < 3; c++) begin
      xneg = acc[c][ACC_W-1];
      xmag = xneg ? ACC_W'(-acc[c]) : ACC_W'(acc[c]);
      if (wz_nxt) begin
        num_nxt[c] = NW'(xmag);
        den_nxt[c] = ACC_W'(1) << FRAC_BITS;
        neg_nxt[c] = xneg;
      end else begin
        num_nxt[c] = NW'(xmag) << FRAC_BITS;
        den_nxt[c] = wmag;
        neg_nxt[c] = xneg ^ wneg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        num_r[c] <= num_nxt[c];
        den_r[c] <= den_nxt[c];
        neg_r[c] <= neg_nxt[c];
      end
      wz_r <= {wz_r[QUO_W:0], wz_nxt};
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    hpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (en),
      .num (num_r[c]),
      .den (den_r[c]),
      .neg (neg_r[c]),
      .res (res[c])
    );
  end

  // clamp to the coordinate range, apply the sign and flag saturation
  always_comb begin
    logic [QUO_W:0]       lim;
    logic [QUO_W:0]       mag;
    logic [QUO_W:0]       sval;
    logic                 clamp;
    logic [COORD_WIDTH-1:0] v [3];
    logic                 sat;
    sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      lim   = res[c].neg ? ((QUO_W+1)'(1) << (QUO_W-1))
                         : (((QUO_W+1)'(1) << (QUO_W-1)) - (QUO_W+1)'(1));
      clamp = res[c].ovf || (res[c].q > lim);
      mag   = clamp ? lim : res[c].q;
      sval  = res[c].neg ? -mag : mag;
      v[c]  = sval[COORD_WIDTH-1:0];
      sat   = sat | clamp;
    end
    out_nxt.out_x      = v[0];
    out_nxt.out_y      = v[1];
    out_nxt.out_z      = v[2];
    out_nxt.w_was_zero = wz_r[QUO_W+1];
    out_nxt.saturated  = sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAST-1:0], in_valid};
      out_valid_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("pipeline held without a waiting result");
  a_zero_w_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[2] && wz_r[0]) |-> (den_r[0] == (ACC_W'(1) << FRAC_BITS)))
    else $error("zero w request not divided by one");
  a_ovf_flags_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[LAST] && (res[0].ovf || res[1].ovf || res[2].ovf)) |=> out_r.saturated)
    else $error("divide overflow without saturation flag");
`endif

endmodule

`default_nettype wire
